[sv/fpa_pkg.sv]
// Shared item type, binary32 constants and rounded float arithmetic.
// Used by the stage, the log front, the exp core, the top level and the testbench; no dependencies.
package fpa_pkg;

    // Item carried down the pipeline; x, y and z are scratch operands
    typedef struct packed {
        logic        cmd;
        logic [31:0] opa;
        logic [31:0] opb;
        logic        spec;
        logic [31:0] spec_val;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } fpa_item_t;

    localparam logic CMD_EXP = 1'b0;
    localparam logic CMD_POW = 1'b1;

    localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] MAXF_BITS  = 32'h7F7F_FFFF;
    localparam logic [30:0] LIMIT_MAG  = 31'h42B0_0000;   // 88.0
    localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE    = 32'hBF80_0000;
    localparam logic [31:0] HALF_BITS  = 32'h3F00_0000;
    localparam logic [31:0] LOG2E_BITS = 32'h3FB8_AA3B;
    localparam logic [31:0] C1_BITS    = 32'h3F31_7218;   // 0.6931472
    localparam logic [31:0] C2_BITS    = 32'h3E75_FDF0;   // 0.2402265
    localparam logic [31:0] C3_BITS    = 32'h3D63_4F0A;   // 0.0554953
    localparam logic [31:0] C4_BITS    = 32'h3C1E_8881;   // 0.0096761
    localparam logic [22:0] MANT_MASK  = 23'h7F_FFFF;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // Leading zeros of a 24-bit significand
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] cnt;
        cnt = 5'd24;
        for (int k = 0; k < 24; k++)
        begin
            if (v[k])
                cnt = 5'(23 - k);
        end
        return cnt;
    endfunction

    // Leading zeros of a 50-bit sum
    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] cnt;
        cnt = 6'd50;
        for (int k = 0; k < 50; k++)
        begin
            if (v[k])
                cnt = 6'(49 - k);
        end
        return cnt;
    endfunction

    // Round to nearest-even and pack; x[47] is the leading one at biased exponent e
    function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] e,
                                               input logic [47:0] x);
        logic [47:0] xs;
        logic        lost;
        logic [9:0]  sh;
        logic [7:0]  field;
        logic [30:0] packed_bits;
        logic        rnd;
        xs    = x;
        lost  = 1'b0;
        sh    = 10'd0;
        field = 8'd0;
        if (e >= 10'sd255)
            return {s, 8'hFF, 23'd0};
        if (e <= 10'sd0)
        begin
            sh = 10'(10'sd1 - e);
            if (sh >= 10'd48)
            begin
                lost = |x;
                xs   = 48'd0;
            end
            else
            begin
                lost = |(x & ~({48{1'b1}} << sh[5:0]));
                xs   = x >> sh[5:0];
            end
        end
        else
            field = e[7:0];
        packed_bits = {field, xs[46:24]};
        rnd = xs[23] & ((|xs[22:0]) | lost | xs[24]);
        return {s, packed_bits + {30'd0, rnd}};
    endfunction

    // Binary32 multiply, round to nearest-even
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic              s;
        logic              az;
        logic              bz;
        logic [23:0]       ma;
        logic [23:0]       mb;
        logic [4:0]        lza;
        logic [4:0]        lzb;
        logic signed [9:0] ea;
        logic signed [9:0] eb;
        logic signed [9:0] e;
        logic [47:0]       p;
        logic [47:0]       x;
        s   = a[31] ^ b[31];
        az  = (a[30:0] == 31'd0);
        bz  = (b[30:0] == 31'd0);
        lza = lzc24({1'b0, a[22:0]});
        lzb = lzc24({1'b0, b[22:0]});
        if (is_nan(a) || is_nan(b))
            return QNAN_BITS;
        if ((is_inf(a) && bz) || (is_inf(b) && az))
            return QNAN_BITS;
        if (is_inf(a) || is_inf(b))
            return {s, 8'hFF, 23'd0};
        if (az || bz)
            return {s, 31'd0};
        // Normalize subnormal inputs
        if (a[30:23] == 8'd0)
        begin
            ma = {1'b0, a[22:0]} << lza;
            ea = 10'sd1 - $signed({5'd0, lza});
        end
        else
        begin
            ma = {1'b1, a[22:0]};
            ea = $signed({2'd0, a[30:23]});
        end
        if (b[30:23] == 8'd0)
        begin
            mb = {1'b0, b[22:0]} << lzb;
            eb = 10'sd1 - $signed({5'd0, lzb});
        end
        else
        begin
            mb = {1'b1, b[22:0]};
            eb = $signed({2'd0, b[30:23]});
        end
        p = ma * mb;
        e = ea + eb - 10'sd127;
        if (p[47])
        begin
            x = p;
            e = e + 10'sd1;
        end
        else
            x = {p[46:0], 1'b0};
        return round_pack(s, e, x);
    endfunction

    // Binary32 add, round to nearest-even
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]       big;
        logic [31:0]       sml;
        logic [7:0]        eb;
        logic [7:0]        es;
        logic [7:0]        d;
        logic [49:0]       av;
        logic [49:0]       bv;
        logic [49:0]       bs;
        logic [49:0]       r;
        logic [49:0]       rn;
        logic [5:0]        lz;
        logic signed [9:0] e;
        if (is_nan(a) || is_nan(b))
            return QNAN_BITS;
        if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
            return QNAN_BITS;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (a[30:0] < b[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d  = eb - es;
        av = {1'b0, (big[30:23] != 8'd0), big[22:0], 25'd0};
        bv = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 25'd0};
        // Align the smaller operand, keep a sticky bit
        if (d >= 8'd50)
            bs = {49'd0, |bv};
        else
            bs = (bv >> d[5:0]) | {49'd0, |(bv & ~({50{1'b1}} << d[5:0]))};
        r = (big[31] ^ sml[31]) ? (av - bs) : (av + bs);
        if (r == 50'd0)
            return {big[31] & sml[31], 31'd0};
        lz = lzc50(r);
        rn = r << lz;
        e  = $signed({2'd0, eb}) + 10'sd1 - $signed({4'd0, lz});
        return round_pack(big[31], e, {rn[49:3], |rn[2:0]});
    endfunction

    // Signed integer to binary32, exact for nine bits
    function automatic logic [31:0] int_to_fp(input logic signed [8:0] v);
        logic        s;
        logic [8:0]  mag;
        logic [3:0]  pos;
        logic [31:0] m;
        s   = v[8];
        mag = s ? 9'(-v) : v;
        pos = 4'd0;
        for (int k = 0; k < 9; k++)
        begin
            if (mag[k])
                pos = 4'(k);
        end
        m = {23'd0, mag} << (5'd23 - {1'b0, pos});
        if (mag == 9'd0)
            return 32'd0;
        return {s, 8'(8'd127 + {4'd0, pos}), m[22:0]};
    endfunction

    // Floor of a binary32 value known to lie within +-127
    function automatic logic signed [7:0] fp_floor(input logic [31:0] t);
        logic [23:0] mant;
        logic [7:0]  sh;
        logic [7:0]  ip;
        logic        frac_nz;
        mant    = {1'b1, t[22:0]};
        sh      = t[30:23] - 8'd127;
        ip      = 8'd0;
        frac_nz = 1'b0;
        if (t[30:23] < 8'd127)
            frac_nz = (t[30:0] != 31'd0);
        else if (t[30:23] <= 8'd133)
        begin
            ip      = 8'(mant >> (5'd23 - sh[4:0]));
            frac_nz = |(mant & ~({24{1'b1}} << (5'd23 - sh[4:0])));
        end
        if (t[31])
            return $signed(8'(-(ip + {7'd0, frac_nz})));
        return $signed(ip);
    endfunction

endpackage

[sv/fpa_stage.sv]
// One pipeline register stage with valid/ready and bubble collapse.
// Depends on fpa_pkg for the item type.
module fpa_stage
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fpa_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output fpa_item_t out_item
);

    logic      valid_reg;
    fpa_item_t item_reg;

    // Take a new item when empty or when the held one leaves
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

endmodule

[sv/fpa_log_unit.sv]
// Power front end: ln(base) from exponent and mantissa, then y = e * ln(base).
// Six register stages, one or two float operations each; depends on fpa_pkg and fpa_stage.
module fpa_log_unit
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fpa_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output fpa_item_t out_item
);

    localparam int NS = 6;

    logic      v   [0:NS];
    logic      rdy [0:NS];
    fpa_item_t s   [0:NS];
    fpa_item_t c   [1:NS];

    assign v[0]      = in_valid;
    assign in_ready  = rdy[0];
    assign s[0]      = in_item;
    assign rdy[NS]   = out_ready;
    assign out_valid = v[NS];
    assign out_item  = s[NS];

    // Stage registers
    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        fpa_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[k-1]),
            .in_ready  (rdy[k-1]),
            .in_item   (c[k]),
            .out_valid (v[k]),
            .out_ready (rdy[k]),
            .out_item  (s[k])
        );
    end

    // d = m - 1, exponent as float, flag NaN and non-positive base
    always_comb
    begin
        c[1]          = s[0];
        c[1].x        = fp_add({1'b0, 8'h7F, s[0].opa[22:0] & MANT_MASK}, NEG_ONE);
        c[1].y        = int_to_fp($signed({1'b0, s[0].opa[30:23]}) - 9'sd127);
        c[1].z        = 32'd0;
        c[1].spec     = 1'b0;
        c[1].spec_val = 32'd0;
        if (s[0].cmd == CMD_POW)
        begin
            if (is_nan(s[0].opa) || is_nan(s[0].opb))
            begin
                c[1].spec     = 1'b1;
                c[1].spec_val = QNAN_BITS;
            end
            else if (s[0].opa[31] || (s[0].opa[30:0] == 31'd0))
            begin
                c[1].spec     = 1'b1;
                c[1].spec_val = 32'd0;
            end
        end
    end

    // h = 0.5 * d, exponent term times ln2
    always_comb
    begin
        c[2]   = s[1];
        c[2].y = fp_mul(s[1].y, C1_BITS);
        c[2].z = fp_mul(HALF_BITS, s[1].x);
    end

    // q = 1 - h
    always_comb
    begin
        c[3]   = s[2];
        c[3].z = fp_add(ONE_BITS, {~s[2].z[31], s[2].z[30:0]});
    end

    // ln_m = d * q
    always_comb
    begin
        c[4]   = s[3];
        c[4].z = fp_mul(s[3].x, s[3].z);
    end

    // ln(base) = exponent term + ln_m
    always_comb
    begin
        c[5]   = s[4];
        c[5].z = fp_add(s[4].y, s[4].z);
    end

    // Select the exp argument: e * ln(base) or the plain operand
    always_comb
    begin
        c[6]   = s[5];
        c[6].x = (s[5].cmd == CMD_POW) ? fp_mul(s[5].opb, s[5].z) : s[5].opa;
    end

endmodule

[sv/fpa_exp_unit.sv]
// Exponential core: clamp, scale by log2(e), floor split, Horner polynomial, 2^i scale.
// Twelve register stages, one float operation each; depends on fpa_pkg and fpa_stage.
module fpa_exp_unit
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fpa_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output fpa_item_t out_item
);

    localparam int NS = 12;

    logic      v   [0:NS];
    logic      rdy [0:NS];
    fpa_item_t s   [0:NS];
    fpa_item_t c   [1:NS];
    logic signed [7:0] fl_int;

    assign v[0]      = in_valid;
    assign in_ready  = rdy[0];
    assign s[0]      = in_item;
    assign rdy[NS]   = out_ready;
    assign out_valid = v[NS];
    assign out_item  = s[NS];

    // Stage registers
    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        fpa_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[k-1]),
            .in_ready  (rdy[k-1]),
            .in_item   (c[k]),
            .out_valid (v[k]),
            .out_ready (rdy[k]),
            .out_item  (s[k])
        );
    end

    // Clamp checks, t = x * log2(e)
    always_comb
    begin
        c[1]   = s[0];
        c[1].y = fp_mul(s[0].x, LOG2E_BITS);
        if (!s[0].spec)
        begin
            if (is_nan(s[0].x))
            begin
                c[1].spec     = 1'b1;
                c[1].spec_val = QNAN_BITS;
            end
            else if (!s[0].x[31] && (s[0].x[30:0] > LIMIT_MAG))
            begin
                c[1].spec     = 1'b1;
                c[1].spec_val = MAXF_BITS;
            end
            else if (s[0].x[31] && (s[0].x[30:0] > LIMIT_MAG))
            begin
                c[1].spec     = 1'b1;
                c[1].spec_val = 32'd0;
            end
        end
    end

    // i = floor(t); keep float(i) and the scale bits (i + 127) << 23
    assign fl_int = fp_floor(s[1].y);

    always_comb
    begin
        c[2]   = s[1];
        c[2].z = int_to_fp({fl_int[7], fl_int});
        c[2].x = {1'b0, 8'($unsigned(fl_int) + 8'd127), 23'd0};
    end

    // f = t - float(i)
    always_comb
    begin
        c[3]   = s[2];
        c[3].y = fp_add(s[2].y, {~s[2].z[31], s[2].z[30:0]});
    end

    // Horner steps
    always_comb
    begin
        c[4]    = s[3];
        c[4].z  = fp_mul(s[3].y, C4_BITS);
        c[5]    = s[4];
        c[5].z  = fp_add(C3_BITS, s[4].z);
        c[6]    = s[5];
        c[6].z  = fp_mul(s[5].y, s[5].z);
        c[7]    = s[6];
        c[7].z  = fp_add(C2_BITS, s[6].z);
        c[8]    = s[7];
        c[8].z  = fp_mul(s[7].y, s[7].z);
        c[9]    = s[8];
        c[9].z  = fp_add(C1_BITS, s[8].z);
        c[10]   = s[9];
        c[10].z = fp_mul(s[9].y, s[9].z);
        c[11]   = s[10];
        c[11].z = fp_add(ONE_BITS, s[10].z);
    end

    // Scale by 2^i, or drop in the special value
    always_comb
    begin
        c[12]   = s[11];
        c[12].z = s[11].spec ? s[11].spec_val : fp_mul(s[11].z, s[11].x);
    end

endmodule

[sv/float_exp_pow_approx.sv]
// Top level of the binary32 exp / pow approximation pipeline.
// Depends on fpa_pkg, fpa_log_unit and fpa_exp_unit.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  input   | in_valid / in_ready  | command, operand_a, operand_b
//  output  | out_valid / out_ready| result
//
// The pipeline has 6 stages in the log front and 12 in the exp core. One
// item enters per cycle unless a stall has backed up to the input.
// Reset clears only the stage valid bits. A stalled output holds its item;
// each stage's ready looks only at the stage after it, so empty stages
// still fill behind a stall.
module float_exp_pow_approx
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result
);

    fpa_item_t in_item;
    fpa_item_t mid_item;
    fpa_item_t out_item;
    logic      mid_valid;
    logic      mid_ready;

    // Pack the incoming item
    always_comb
    begin
        in_item     = '0;
        in_item.cmd = command;
        in_item.opa = operand_a;
        in_item.opb = operand_b;
    end

    fpa_log_unit u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    fpa_exp_unit u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign result = out_item.z;

endmodule

[sv/fpa_checker.sv]
// Port-level checks for float_exp_pow_approx, bound to the top level.
// Depends only on the top level's ports.
module fpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("stalled result changed");

    // Come out of reset empty
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // Never stall the input while the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled with a free output");

    // Results are never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !result[31])
        else $error("negative result");

    // The only non-finite result is the canonical NaN
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result[30:23] == 8'hFF) |-> result == 32'h7FC0_0000)
        else $error("non-canonical special result");

endmodule

bind float_exp_pow_approx fpa_checker u_fpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);

[tb/sv/approx_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for float_exp_pow_approx: watches both channels, computes the
// expected binary32 result of every accepted item and compares in order.
// Depends on fpa_pkg for the command codes only.
module approx_result_checker
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        command,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] result,
    output int          mismatches,
    output int          pending
);

    localparam logic [31:0] NAN_Q    = 32'h7FC0_0000;
    localparam logic [31:0] MAX_F    = 32'h7F7F_FFFF;
    localparam logic [30:0] CLAMP    = 31'h42B0_0000;
    localparam logic [31:0] F_ONE    = 32'h3F80_0000;
    localparam logic [31:0] F_MONE   = 32'hBF80_0000;
    localparam logic [31:0] F_HALF   = 32'h3F00_0000;
    localparam logic [31:0] F_LOG2E  = 32'h3FB8_AA3B;
    localparam logic [31:0] K1       = 32'h3F31_7218;
    localparam logic [31:0] K2       = 32'h3E75_FDF0;
    localparam logic [31:0] K3       = 32'h3D63_4F0A;
    localparam logic [31:0] K4       = 32'h3C1E_8881;

    logic [31:0] expected_q[$];

    function automatic bit sp_nan(input bit [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic bit sp_inf(input bit [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 0;
    endfunction

    // Value is m * 2^e exactly
    function automatic void sp_split(input bit [31:0] v, output bit [95:0] m, output int e);
        if (v[30:23] == 0)
        begin
            m = {73'd0, v[22:0]};
            e = -149;
        end
        else
        begin
            m = {72'd0, 1'b1, v[22:0]};
            e = int'(v[30:23]) - 150;
        end
    endfunction

    // Round s * m * 2^e to binary32, nearest-even
    function automatic bit [31:0] sp_round(input bit s, input bit [95:0] m, input int e);
        int        p;
        int        lsb;
        int        sh;
        bit [95:0] q;
        bit        g;
        bit        st;
        if (m == 0)
            return {s, 31'd0};
        p = 0;
        for (int k = 0; k < 96; k++)
            if (m[k])
                p = k;
        lsb = (p + e < -126) ? -149 : p + e - 23;
        sh  = lsb - e;
        if (sh > 96)
            q = 0;
        else if (sh > 0)
        begin
            q  = m >> sh;
            g  = m[sh-1];
            st = |(m & ((96'd1 << (sh - 1)) - 1));
            if (g && (st || q[0]))
                q = q + 1;
        end
        else
            q = m << (-sh);
        if (q[24])
        begin
            q   = q >> 1;
            lsb = lsb + 1;
        end
        if (lsb > 104)
            return {s, 8'hFF, 23'd0};
        if (!q[23])
            return {s, 8'd0, q[22:0]};
        return {s, 8'(lsb + 150), q[22:0]};
    endfunction

    function automatic bit [31:0] sp_mul(input bit [31:0] a, input bit [31:0] b);
        bit        s;
        bit [95:0] ma;
        bit [95:0] mb;
        int        ea;
        int        eb;
        s = a[31] ^ b[31];
        if (sp_nan(a) || sp_nan(b))
            return NAN_Q;
        if ((sp_inf(a) && b[30:0] == 0) || (sp_inf(b) && a[30:0] == 0))
            return NAN_Q;
        if (sp_inf(a) || sp_inf(b))
            return {s, 8'hFF, 23'd0};
        sp_split(a, ma, ea);
        sp_split(b, mb, eb);
        return sp_round(s, ma * mb, ea + eb);
    endfunction

    function automatic bit [31:0] sp_add(input bit [31:0] a, input bit [31:0] b);
        bit [95:0] ma;
        bit [95:0] mb;
        bit [95:0] tm;
        int        ea;
        int        eb;
        int        d;
        bit        sa;
        bit        sb;
        bit        tb_s;
        if (sp_nan(a) || sp_nan(b))
            return NAN_Q;
        if (sp_inf(a) && sp_inf(b) && a[31] != b[31])
            return NAN_Q;
        if (sp_inf(a))
            return a;
        if (sp_inf(b))
            return b;
        sp_split(a, ma, ea);
        sp_split(b, mb, eb);
        sa = a[31];
        sb = b[31];
        // Keep the larger exponent in a
        if (eb > ea)
        begin
            tm = ma; ma = mb; mb = tm;
            d = ea; ea = eb; eb = d;
            tb_s = sa; sa = sb; sb = tb_s;
        end
        d = ea - eb;
        // Far-off operand only matters as a sticky bit
        if (d > 60)
        begin
            mb = (mb != 0);
            d  = 60;
        end
        ma = ma << d;
        if (sa == sb)
            return sp_round(sa, ma + mb, ea - d);
        if (ma == mb)
            return {sa & sb, 31'd0};
        if (ma > mb)
            return sp_round(sa, ma - mb, ea - d);
        return sp_round(sb, mb - ma, ea - d);
    endfunction

    function automatic int sp_floor(input bit [31:0] t);
        bit [95:0] m;
        int        e;
        int        ip;
        bit        fr;
        sp_split(t, m, e);
        if (e >= 0)
        begin
            ip = int'(m << e);
            fr = 0;
        end
        else if (-e >= 48)
        begin
            ip = 0;
            fr = (m != 0);
        end
        else
        begin
            ip = int'(m >> (-e));
            fr = |(m & ((96'd1 << (-e)) - 1));
        end
        return t[31] ? -(ip + int'(fr)) : ip;
    endfunction

    function automatic bit [31:0] sp_from_int(input int i);
        return sp_round(i < 0, 96'(i < 0 ? -i : i), 0);
    endfunction

    // Clamp, split into 2^i * poly(f)
    function automatic bit [31:0] predict_exp(input bit [31:0] x);
        bit [31:0] t;
        bit [31:0] f;
        bit [31:0] p;
        int        i;
        if (sp_nan(x))
            return NAN_Q;
        if (!x[31] && x[30:0] > CLAMP)
            return MAX_F;
        if (x[31] && x[30:0] > CLAMP)
            return 32'd0;
        t = sp_mul(x, F_LOG2E);
        i = sp_floor(t);
        f = sp_add(t, sp_from_int(i) ^ 32'h8000_0000);
        p = sp_mul(f, K4);
        p = sp_add(K3, p);
        p = sp_mul(f, p);
        p = sp_add(K2, p);
        p = sp_mul(f, p);
        p = sp_add(K1, p);
        p = sp_mul(f, p);
        p = sp_add(F_ONE, p);
        return sp_mul(p, {1'b0, 8'(i + 127), 23'd0});
    endfunction

    // ln(base) from exponent field plus mantissa quadratic, then exp
    function automatic bit [31:0] predict_pow(input bit [31:0] base, input bit [31:0] ex);
        bit [31:0] d;
        bit [31:0] q;
        bit [31:0] ln_b;
        if (sp_nan(base) || sp_nan(ex))
            return NAN_Q;
        if (base[31] || base[30:0] == 0)
            return 32'd0;
        d    = sp_add({9'h07F, base[22:0]}, F_MONE);
        q    = sp_add(F_ONE, sp_mul(F_HALF, d) ^ 32'h8000_0000);
        ln_b = sp_mul(sp_from_int(int'(base[30:23]) - 127), K1);
        ln_b = sp_add(ln_b, sp_mul(d, q));
        return predict_exp(sp_mul(ex, ln_b));
    endfunction

    assign pending = expected_q.size();

    // Queue predictions on input items, compare on result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(command == CMD_EXP ? predict_exp(operand_a)
                                                        : predict_pow(operand_a, operand_b));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %h", result);
                    mismatches <= mismatches + 1;
                end
                else if (expected_q[0] !== result)
                begin
                    if (mismatches < 10)
                        $display("result mismatch: expected %h, got %h", expected_q[0], result);
                    mismatches <= mismatches + 1;
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the float_exp_pow_approx testbench: clock, reset, stimulus, verdict.
// Depends on fpa_pkg, float_exp_pow_approx and approx_result_checker.
module tb;
    import fpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result;
    int          mismatches;
    int          pending;
    int          cycles;
    int          stall;
    int          out_gap;
    int          n_exp;
    int          n_pow;
    bit          quiet;

    float_exp_pow_approx i_dut (.*);

    approx_result_checker i_chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: draw a stall after every taken result, none in quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall     <= 0;
        end
        else if (out_ready && out_valid)
        begin
            if (quiet)
            begin
                stall     <= 0;
                out_ready <= 1'b1;
            end
            else
            begin
                out_gap = $urandom_range(0, 10);
                stall     <= out_gap;
                out_ready <= (out_gap == 0) ? 1'b1 : 1'b0;
            end
        end
        else if (!out_ready)
        begin
            if (stall <= 1)
                out_ready <= 1'b1;
            stall <= (stall > 0) ? stall - 1 : 0;
        end
    end

    // Hold one item until taken; lower valid only across a gap
    task automatic send_item(input logic cmd, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == CMD_EXP)
            n_exp++;
        else
            n_pow++;
    endtask

    function automatic logic [31:0] rand_float(input int lo, input int hi);
        return {1'($urandom_range(0, 1)), 8'($urandom_range(lo, hi)), 23'($urandom)};
    endfunction

    initial
    begin
        int          sel;
        logic [31:0] a;
        logic [31:0] b;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_EXP;
        operand_a = '0;
        operand_b = '0;
        cycles    = 0;
        n_exp     = 0;
        n_pow     = 0;
        quiet     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed exp: zero, clamp edges, infinities, NaN, subnormal, floor of -127
        send_item(CMD_EXP, 32'h0000_0000, '0);
        send_item(CMD_EXP, 32'h8000_0000, '0);
        send_item(CMD_EXP, 32'h42B0_0000, '0);
        send_item(CMD_EXP, 32'h42B0_0001, '0);
        send_item(CMD_EXP, 32'hC2B0_0000, '0);
        send_item(CMD_EXP, 32'hC2B0_0001, '0);
        send_item(CMD_EXP, 32'h7F80_0000, '0);
        send_item(CMD_EXP, 32'hFF80_0000, '0);
        send_item(CMD_EXP, 32'hFFFF_FFFF, '0);
        send_item(CMD_EXP, 32'h0000_0001, '0);
        send_item(CMD_EXP, 32'hC2AF_CCCD, '0);
        send_item(CMD_EXP, 32'h3F80_0000, '1);
        // Directed pow: NaNs, non-positive bases, inf and subnormal bases, inf*0
        send_item(CMD_POW, 32'h7FC0_0001, 32'h3F80_0000);
        send_item(CMD_POW, 32'h4000_0000, 32'hFFC0_0000);
        send_item(CMD_POW, 32'h0000_0000, 32'h4000_0000);
        send_item(CMD_POW, 32'h8000_0000, 32'h4000_0000);
        send_item(CMD_POW, 32'hC000_0000, 32'h4000_0000);
        send_item(CMD_POW, 32'h7F80_0000, 32'h0000_0000);
        send_item(CMD_POW, 32'h7F80_0000, 32'h3F00_0000);
        send_item(CMD_POW, 32'h0000_0001, 32'hBF80_0000);
        send_item(CMD_POW, 32'h3F80_0000, 32'h7F80_0000);
        send_item(CMD_POW, 32'h4000_0000, 32'h4120_0000);
        send_item(CMD_POW, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_item(CMD_POW, 32'h3FFF_FFFF, 32'hBFFF_FFFF);

        // Let the pipeline drain completely before random traffic
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < 550; n++)
        begin
            // Alternate stretches with and without idling
            if (n % 100 == 0)
                quiet = (n % 200 == 100);
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                a = $urandom;
                b = $urandom;
            end
            else if (sel < 5)
            begin
                a = rand_float(100, 133);
                b = $urandom;
            end
            else
            begin
                a = rand_float(100, 150);
                a[31] = ($urandom_range(0, 15) == 0);
                b = rand_float(110, 132);
            end
            send_item(sel < 5 ? CMD_EXP : 1'($urandom_range(0, 1)), a, b);
        end
        in_valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d exp items and %0d pow items, with and without idling",
                 n_exp, n_pow);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
